/* rtl/core/jsu_pkg.sv */
// shared types and constants for the json string unescape block
`default_nettype none

package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_UNTERM = 2'd2;
  localparam logic [1:0] KIND_NOSTR  = 2'd3;

  localparam int unsigned MAX_BEATS = 4;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } beat_t;

  // all result words caused by one source byte
  typedef struct packed {
    beat_t [MAX_BEATS-1:0] beats;
    logic [1:0]            last_idx;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/jsu_front.sv */
// front end: scanner state and per-byte classification into result bundles
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output cmd_t            cmd,
  output logic            push
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } utf8_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic [7:0] escape_char(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [15:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 16'h0080) begin
      u.len      = 2'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      u.len      = 2'd2;
      u.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      u.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      u.len      = 2'd3;
      u.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      u.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      u.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return u;
  endfunction

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [15:0] cp_r, cp_nxt;

  always_comb begin
    logic [2:0]  n;
    logic        open;
    logic [15:0] cp_hex;
    utf8_t       u;
    n          = 3'd0;
    open       = 1'b0;
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    cp_nxt     = cp_r;
    cmd        = '0;
    cp_hex     = {cp_r[11:0], hex_value(in_byte)};
    u          = utf8_enc(cp_hex);

    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = MODE_STR;
          open     = 1'b1;
        end else begin
          cmd.beats[n[1:0]] = '{data: 8'h00, kind: KIND_NOSTR};
          n = n + 3'd1;
        end
      end
      MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          cmd.beats[n[1:0]] = '{data: 8'h00, kind: KIND_CLOSE};
          n        = n + 3'd1;
          mode_nxt = MODE_IDLE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = MODE_ESC;
          open     = 1'b1;
        end else begin
          cmd.beats[n[1:0]] = '{data: in_byte, kind: KIND_BYTE};
          n    = n + 3'd1;
          open = 1'b1;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          mode_nxt   = MODE_HEX;
          digits_nxt = 2'd0;
          cp_nxt     = 16'h0000;
        end else begin
          cmd.beats[n[1:0]] = '{data: escape_char(in_byte), kind: KIND_BYTE};
          n        = n + 3'd1;
          mode_nxt = MODE_STR;
        end
        open = 1'b1;
      end
      MODE_HEX: begin
        cp_nxt = cp_hex;
        if (digits_r == 2'd3) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < u.len) begin
              cmd.beats[n[1:0]] = '{data: u.bytes[i], kind: KIND_BYTE};
              n = n + 3'd1;
            end
          end
          mode_nxt   = MODE_STR;
          digits_nxt = 2'd0;
          cp_nxt     = 16'h0000;
        end else begin
          digits_nxt = digits_r + 2'd1;
        end
        open = 1'b1;
      end
    endcase

    // end of input: flush partial hex, then the unterminated marker
    if (in_last) begin
      if (open) begin
        if (mode_nxt == MODE_HEX) begin
          u = utf8_enc(cp_nxt);
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < u.len) begin
              cmd.beats[n[1:0]] = '{data: u.bytes[i], kind: KIND_BYTE};
              n = n + 3'd1;
            end
          end
        end
        cmd.beats[n[1:0]] = '{data: 8'h00, kind: KIND_UNTERM};
        n = n + 3'd1;
      end
      mode_nxt   = MODE_IDLE;
      digits_nxt = 2'd0;
      cp_nxt     = 16'h0000;
    end

    cmd.last_idx = 2'(n - 3'd1);
    push         = fire && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      digits_r <= 2'd0;
      cp_r     <= 16'h0000;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      cp_r     <= cp_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_fifo.sv */
// short queue of result bundles between front and back
`default_nettype none

module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          store_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_cmd    = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_back.sv */
// back end: plays out one bundle a word at a time into the output register
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_run_last
);

  cmd_t       cmd_r;
  logic [1:0] beat_r;
  logic       valid_r;
  logic       at_last;
  logic       done;

  assign at_last      = (beat_r == cmd_r.last_idx);
  assign done         = valid_r && out_ready && at_last;
  assign q_pop        = q_valid && (!valid_r || done);
  assign out_valid    = valid_r;
  assign out_byte     = cmd_r.beats[beat_r].data;
  assign out_kind     = cmd_r.beats[beat_r].kind;
  assign out_run_last = at_last;

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= 2'd0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      beat_r  <= 2'd0;
    end else if (done) begin
      valid_r <= 1'b0;
      beat_r  <= 2'd0;
    end else if (valid_r && out_ready) begin
      beat_r  <= beat_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape_top.sv */
// top level of the json string literal decoder
// path: scanner (combinational), then bundle queue, then the back end output register
// throughput: one source byte per cycle while the queue has room, one word per cycle while out_ready is set
// a byte causing up to four result words holds the output until all of them have been taken
// the bundle queue depth (FIFO_DEPTH) sets how many bytes that yield words can be absorbed ahead of the output
// reset: synchronous active-low rst_n returns the scanner to idle and empties queue and output
`default_nettype none

module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // source byte channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  // result word channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_run_last
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic in_fire;

  // the front only stalls when the queue has no room for another bundle
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // scanner: tracks string, escape and hex state, builds one bundle per source byte that yields result words
  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .cmd     (front_cmd),
    .push    (front_push)
  );

  // decouples the scanner from output back-pressure
  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .wr_cmd    (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .rd_cmd    (q_cmd),
    .not_empty (q_valid)
  );

  // serialiser: one result word per cycle from the head bundle while out_ready is high
  jsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_run_last (out_run_last)
  );

  // marker words carry a zero data byte
  a_marker_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_byte == 8'h00)
    else $error("marker word with non-zero data");

  // close, unterminated and not-a-string markers always end their run
  a_marker_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_run_last)
    else $error("marker word not flagged as last of run");

  // a full queue blocks the input
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ready && !front_push)
    else $error("push into full queue");

  // reset empties the output
  a_reset_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the json string unescape block: directed table, random literals, stray bytes

module testbench;
  import jsu_pkg::*;

  // run shape
  localparam int N_RANDOM    = 390;  // minimum count of random source bytes after the directed table
  localparam int IDLE_PCT    = 37;   // chance in a hundred that a side idles in a cycle
  localparam int TAIL_CYCLES = 12;   // quiet tail at the end of the run, with margin for a late word
  localparam int STALL_LIMIT = 2000; // cycles with no word moving on either side
  localparam int PRINT_CAP   = 30;

  // characters the scanner reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0]  ESCAPES [0:7]  = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
  localparam logic [15:0] CP_EDGES [0:5] = '{16'h0000, 16'h007F, 16'h0080,
                                             16'h07FF, 16'h0800, 16'hFFFF};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_TEXT, SCAN_ESCAPE, SCAN_HEX} scan_mode_t;

  // one result word as the scoreboard holds it
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       run_last;
  } word_t;

  // one source byte; typed rows carry their single expected word with them
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [1:0] kind;
    logic [7:0] want;
  } src_t;

  // directed opening: extremes, every scanner state, every way of running out of input
  localparam src_t OPENING [0:24] = '{
    '{8'h00,     1'b0, 1'b1, KIND_NOSTR,  8'h00}, // idle, lowest byte: not a string
    '{8'hFF,     1'b0, 1'b1, KIND_NOSTR,  8'h00}, // idle, highest byte
    '{CH_QUOTE,  1'b1, 1'b1, KIND_UNTERM, 8'h00}, // quote as the last byte: empty and open
    '{"a",       1'b1, 1'b1, KIND_NOSTR,  8'h00}, // idle non-quote as the last byte
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,   8'h00}, // open, nothing comes out
    '{8'h00,     1'b0, 1'b0, KIND_BYTE,   8'h00}, // plain bytes at both extremes
    '{8'hFF,     1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{"n",       1'b0, 1'b0, KIND_BYTE,   8'h00}, // mapped escape
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_U,      1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{"F",       1'b0, 1'b0, KIND_BYTE,   8'h00}, // upper and lower case digits
    '{"f",       1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{"z",       1'b0, 1'b0, KIND_BYTE,   8'h00}, // non-hex digit counts as zero
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,   8'h00}, // a quote in hex position too: three bytes
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_U,      1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{"0",       1'b1, 1'b0, KIND_BYTE,   8'h00}, // input ends mid hex: flush, then unterminated
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_BSLASH, 1'b1, 1'b1, KIND_UNTERM, 8'h00}, // input ends after backslash: backslash dropped
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_QUOTE,  1'b1, 1'b1, KIND_CLOSE,  8'h00}, // closing quote as the last byte: close only
    '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,   8'h00},
    '{CH_U,      1'b1, 1'b0, KIND_BYTE,   8'h00}  // u itself last: zero digits flushed
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_run_last;

  // source bytes in order, and words still owed by the block
  src_t  src_bytes [$];
  word_t due_words [$];
  word_t step_out  [$];

  // scanner state as predicted
  scan_mode_t  scan_mode = SCAN_IDLE;
  logic [1:0]  hex_count = 2'd0;
  logic [15:0] hex_acc   = 16'h0000;

  int src_idx     = 0;
  int words_seen  = 0;
  int mismatches  = 0;
  int n_literals  = 0;
  int idle_cycles = 0;
  int pause_at;
  int kind_seen [0:3] = '{0, 0, 0, 0};

  always #6 clk = ~clk;

  json_string_unescape_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_run_last (out_run_last)
  );

  function automatic word_t mk_word(logic [7:0] d, logic [1:0] k);
    return '{data: d, kind: k, run_last: 1'b0};
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'h0;
  endfunction

  function automatic logic [7:0] escape_target(logic [7:0] c);
    case (c)
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return c;     // quote, backslash, slash and unknown escapes pass through
    endcase
  endfunction

  // code point to one, two or three utf-8 bytes; surrogates get no special treatment
  function automatic void push_utf8(logic [15:0] cp);
    if (cp < 16'h0080) begin
      step_out.push_back(mk_word(cp[7:0], KIND_BYTE));
    end else if (cp < 16'h0800) begin
      step_out.push_back(mk_word({3'b110, cp[10:6]}, KIND_BYTE));
      step_out.push_back(mk_word({2'b10, cp[5:0]}, KIND_BYTE));
    end else begin
      step_out.push_back(mk_word({4'hE, cp[15:12]}, KIND_BYTE));
      step_out.push_back(mk_word({2'b10, cp[11:6]}, KIND_BYTE));
      step_out.push_back(mk_word({2'b10, cp[5:0]}, KIND_BYTE));
    end
  endfunction

  // advance the predicted scanner by one source byte, leaving its words in step_out
  task automatic unescape_step(input logic [7:0] c, input logic last);
    logic  open;
    word_t tail;
    open = 1'b1;
    step_out.delete();
    case (scan_mode)
      SCAN_IDLE: begin
        if (c == CH_QUOTE) begin
          scan_mode = SCAN_TEXT;
        end else begin
          step_out.push_back(mk_word(8'h00, KIND_NOSTR));
          open = 1'b0;
        end
      end
      SCAN_TEXT: begin
        if (c == CH_QUOTE) begin
          step_out.push_back(mk_word(8'h00, KIND_CLOSE));
          scan_mode = SCAN_IDLE;
          open = 1'b0;
        end else if (c == CH_BSLASH) begin
          scan_mode = SCAN_ESCAPE;
        end else begin
          step_out.push_back(mk_word(c, KIND_BYTE));
        end
      end
      SCAN_ESCAPE: begin
        if (c == CH_U) begin
          scan_mode = SCAN_HEX;
          hex_count = 2'd0;
          hex_acc = 16'h0000;
        end else begin
          step_out.push_back(mk_word(escape_target(c), KIND_BYTE));
          scan_mode = SCAN_TEXT;
        end
      end
      default: begin
        hex_acc = {hex_acc[11:0], hex_nibble(c)};
        if (hex_count == 2'd3) begin
          push_utf8(hex_acc);
          scan_mode = SCAN_TEXT;
          hex_count = 2'd0;
          hex_acc = 16'h0000;
        end else begin
          hex_count = hex_count + 2'd1;
        end
      end
    endcase
    if (last) begin
      if (open) begin
        if (scan_mode == SCAN_HEX) push_utf8(hex_acc);
        step_out.push_back(mk_word(8'h00, KIND_UNTERM));
      end
      scan_mode = SCAN_IDLE;
      hex_count = 2'd0;
      hex_acc = 16'h0000;
    end
    if (step_out.size() != 0) begin
      tail = step_out.pop_back();
      tail.run_last = 1'b1;
      step_out.push_back(tail);
    end
  endtask

  task automatic push_src(input logic [7:0] b, input logic l);
    src_bytes.push_back('{data: b, last: l, typed: 1'b0, kind: KIND_BYTE, want: 8'h00});
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // one string literal with random content; sometimes cut short, sometimes ending the input
  task automatic gen_literal();
    logic [7:0]  lit [$];
    logic [7:0]  b;
    logic [15:0] cp;
    logic [3:0]  nib;
    int          n_parts;
    int          r;
    int          p;
    int          d;
    int          cut;
    lit.push_back(CH_QUOTE);
    n_parts = $urandom_range(8);
    for (p = 0; p < n_parts; p++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        lit.push_back(b);
      end else if (r < 70) begin
        lit.push_back(CH_BSLASH);
        // mostly the known escapes, now and then any byte at all
        lit.push_back(r < 64 ? ESCAPES[$urandom_range(7)] : 8'($urandom_range(255)));
      end else begin
        lit.push_back(CH_BSLASH);
        lit.push_back(CH_U);
        case ($urandom_range(5))
          0:       cp = 16'($urandom_range(16'h007F));
          1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
          2, 3:    cp = 16'($urandom_range(16'hFFFF, 16'h0800));
          default: cp = CP_EDGES[$urandom_range(5)];
        endcase
        for (d = 3; d >= 0; d--) begin
          nib = cp[4*d +: 4];
          if ($urandom_range(19) == 0) b = 8'($urandom_range(255)); // stray digit
          else if (nib < 4'd10) b = 8'h30 + 8'(nib);
          else b = ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
          lit.push_back(b);
        end
      end
    end
    lit.push_back(CH_QUOTE);
    // below 22: cut at a random byte, possibly the closing quote, with last there; below 45: last on the closing quote
    r = $urandom_range(99);
    cut = (r < 22) ? int'($urandom_range(lit.size() - 1)) : lit.size() - 1;
    for (p = 0; p <= cut; p++) push_src(lit[p], p == cut && r < 45);
  endtask

  // build the whole source stream while reset is held, then release reset
  initial begin : stimulus
    logic [7:0] b;
    int         i;
    for (i = 0; i < $size(OPENING); i++) src_bytes.push_back(OPENING[i]);
    while (src_bytes.size() < $size(OPENING) + N_RANDOM) begin
      if ($urandom_range(99) < 10) begin
        // stray text between literals
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
        push_src(b, $urandom_range(7) == 0);
      end else begin
        gen_literal();
        n_literals++;
      end
    end
    pause_at = $size(OPENING) + 250;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // both channels in one process so the prediction always lands before the check
  always @(posedge clk) begin : traffic
    word_t want;
    logic  quiet_tx;
    logic  hold;
    logic  send;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // source word taken at this edge: predict what it causes
      if (in_valid && in_ready) begin
        unescape_step(src_bytes[src_idx].data, src_bytes[src_idx].last);
        if (src_bytes[src_idx].typed)
          due_words.push_back('{data: src_bytes[src_idx].want, kind: src_bytes[src_idx].kind,
                                run_last: 1'b1});
        else
          foreach (step_out[k]) due_words.push_back(step_out[k]);
        src_idx++;
      end

      // result word taken at this edge: compare with the oldest one owed
      if (out_valid && out_ready) begin
        words_seen++;
        kind_seen[out_kind]++;
        if (due_words.size() == 0) begin
          flag_mismatch($sformatf("word %0d unexpected: byte %02h kind %0d run_last %0b",
                                  words_seen, out_byte, out_kind, out_run_last));
        end else begin
          want = due_words.pop_front();
          if (out_byte !== want.data || out_kind !== want.kind ||
              out_run_last !== want.run_last)
            flag_mismatch($sformatf("word %0d: got byte %02h kind %0d run_last %0b, want %02h %0d %0b",
                                    words_seen, out_byte, out_kind, out_run_last,
                                    want.data, want.kind, want.run_last));
        end
      end

      // next source word, unless the current one is still waiting to be taken
      if (!(in_valid && !in_ready)) begin
        quiet_tx = src_idx >= $size(OPENING) + 60 && src_idx < $size(OPENING) + 160;
        // once in the run the sender drains the block completely before going on
        hold = src_idx == pause_at && due_words.size() != 0;
        send = src_idx < src_bytes.size() && !hold &&
               (quiet_tx || $urandom_range(99) >= IDLE_PCT);
        in_valid <= send;
        if (send) begin
          in_byte <= src_bytes[src_idx].data;
          in_last <= src_bytes[src_idx].last;
        end
      end

      // receiver stalls at random, apart from one long stretch of steady acceptance
      out_ready <= (words_seen >= 150 && words_seen < 300) || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d source bytes and %0d words owed",
               STALL_LIMIT, src_bytes.size() - src_idx, due_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // end of run: everything sent, everything received, then a short quiet tail
  initial begin
    @(posedge rst_n);
    while (src_idx < src_bytes.size() || due_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_words.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", due_words.size()));
    $display("summary: %0d source bytes incl. %0d random literals, %0d result words checked",
             src_idx, n_literals, words_seen);
    $display("summary: %0d data, %0d closed, %0d unterminated, %0d not a string, %0d mismatches",
             kind_seen[KIND_BYTE], kind_seen[KIND_CLOSE], kind_seen[KIND_UNTERM],
             kind_seen[KIND_NOSTR], mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
